/* hw/rtl/ed2cd_pkg.sv */
package ed2cd_pkg;

    localparam int unsigned BaseYear = 2000;

    // Seconds are first shifted down by 7, leaving a division by 675 (86400 = 128 * 675).
    localparam int unsigned SecShift     = 7;
    localparam int unsigned SecDivisor   = 675;
    localparam int unsigned SecRecipBits = 35;
    localparam logic [25:0] SecRecip     = 26'd50903316;

    localparam logic [10:0] CycleDays      = 11'd1461;
    localparam int unsigned CycleRecipBits = 26;
    localparam logic [15:0] CycleRecip     = 16'd45934;

    localparam logic [16:0] SecPerHour = 17'd3600;

    localparam logic [8:0] LeapYearDays = 9'd366;
    localparam logic [8:0] YearDays     = 9'd365;

    typedef logic [47:0] in_data_t;
    typedef logic [31:0] out_data_t;

    // First day of month k (0 = January) within the year, counted from 0.
    function automatic logic [8:0] month_start(input logic [3:0] k, input logic leap);
        logic [8:0] base;
        begin
            case (k)
                4'd0:    base = 9'd0;
                4'd1:    base = 9'd31;
                4'd2:    base = 9'd59;
                4'd3:    base = 9'd90;
                4'd4:    base = 9'd120;
                4'd5:    base = 9'd151;
                4'd6:    base = 9'd181;
                4'd7:    base = 9'd212;
                4'd8:    base = 9'd243;
                4'd9:    base = 9'd273;
                4'd10:   base = 9'd304;
                4'd11:   base = 9'd334;
                default: base = 9'd0;
            endcase
            if (leap && (k >= 4'd2))
            begin
                base = base + 9'd1;
            end
            return base;
        end
    endfunction

endpackage

/* hw/rtl/epoch_days_to_calendar_date.sv */
// Converts a day count or a seconds count since the start of 2000 into a calendar date.
// The input channel (s_tvalid, s_tready, s_tdata, s_tuser) carries one value per transfer;
// s_tuser selects seconds mode, in which the hour is also produced.
// The output channel (m_tvalid, m_tready, m_tdata, m_tuser) returns one date per input
// transfer, in order; m_tuser is low when the day count is zero and no date exists.
// The block is a six-stage pipeline: each input transfer passes through the stage registers
// in order, and a new input can be taken in every cycle while the output is empty or
// m_tready is high, so the sustained rate is one item per clock. The stages hold the
// seconds-to-days reciprocal multiplier and its correction stage, the days-to-cycles
// reciprocal multiplier, the remainder within the four-year cycle, and the year and
// month decoding stages.
// Reset clears all stage valid bits, so the output channel comes up empty.
// When the receiver holds m_tready low with a result waiting, every stage holds its
// contents and s_tready falls; items already in flight are neither lost nor repeated,
// and the pipeline resumes as soon as the result is taken.
module epoch_days_to_calendar_date (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  ed2cd_pkg::in_data_t  s_tdata,  // day_count[15:0], seconds_value[47:16]
    input  logic                 s_tuser,  // mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output ed2cd_pkg::out_data_t m_tdata,  // year[11:0], month[15:12], day_of_month[20:16],
                                           // hour[25:21], zero fill [31:26]
    output logic                 m_tuser   // date_valid
);
    import ed2cd_pkg::*;

    logic [5:0] vld_reg;
    logic       adv;

    // Stage 1
    logic        mode_1_reg;
    logic [15:0] dc_1_reg;
    logic [24:0] x_1_reg;
    logic [6:0]  lo_1_reg;
    logic [50:0] prod_1_reg;

    // Stage 2
    logic [15:0] days_2_reg;
    logic [16:0] rsec_2_reg;
    logic [15:0] qe_2;
    logic [25:0] r_full_2;
    logic [9:0]  r_2;
    logic [15:0] q_2;

    // Stage 3
    logic [15:0] days_3_reg;
    logic [31:0] prod_3_reg;
    logic [4:0]  hour_3_reg;
    logic [4:0]  hour_cnt;

    // Stage 4
    logic [5:0]  cyc_4_reg;
    logic [10:0] rem_4_reg;
    logic        zero_4_reg;
    logic [4:0]  hour_4_reg;
    logic [5:0]  cyc_4;
    logic [16:0] cyc_days_4;

    // Stage 5
    logic [11:0] year_5_reg;
    logic [8:0]  doy_5_reg;
    logic        leap_5_reg;
    logic        zero_5_reg;
    logic [4:0]  hour_5_reg;
    logic [1:0]  yoff_5;
    logic [10:0] ysub_5;

    // Stage 6 (output)
    out_data_t   data_6_reg;
    logic        valid_6_reg;
    logic [3:0]  mon_idx;
    logic [8:0]  mday;
    logic [3:0]  month_6;
    logic [4:0]  day_6;
    logic [11:0] year_6;

    assign adv      = ~vld_reg[5] | m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[5];
    assign m_tdata  = data_6_reg;
    assign m_tuser  = valid_6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[4:0], s_tvalid};
        end
    end

    // Stage 2 logic: correct the reciprocal estimate of seconds / 86400.
    always_comb
    begin
        qe_2     = prod_1_reg[SecRecipBits +: 16];
        r_full_2 = {1'b0, x_1_reg} - 26'(qe_2) * 26'(SecDivisor);
        if (r_full_2 >= 26'(SecDivisor))
        begin
            q_2 = qe_2 + 16'd1;
            r_2 = 10'(r_full_2 - 26'(SecDivisor));
        end
        else
        begin
            q_2 = qe_2;
            r_2 = r_full_2[9:0];
        end
    end

    // Stage 3 logic: hour from the seconds within the day.
    always_comb
    begin
        hour_cnt = '0;
        for (int k = 1; k < 24; k++)
        begin
            if (rsec_2_reg >= 17'(k) * SecPerHour)
            begin
                hour_cnt = hour_cnt + 5'd1;
            end
        end
    end

    // Stage 4 logic: remainder within the four-year cycle.
    assign cyc_4      = prod_3_reg[CycleRecipBits +: 6];
    assign cyc_days_4 = 17'(cyc_4) * 17'(CycleDays);

    // Stage 5 logic: year within the cycle and day of the year.
    always_comb
    begin
        if (rem_4_reg < 11'(LeapYearDays))
        begin
            yoff_5 = 2'd0;
            ysub_5 = 11'd0;
        end
        else if (rem_4_reg < 11'(LeapYearDays) + 11'(YearDays))
        begin
            yoff_5 = 2'd1;
            ysub_5 = 11'(LeapYearDays);
        end
        else if (rem_4_reg < 11'(LeapYearDays + 2 * YearDays))
        begin
            yoff_5 = 2'd2;
            ysub_5 = 11'(LeapYearDays) + 11'(YearDays);
        end
        else
        begin
            yoff_5 = 2'd3;
            ysub_5 = 11'(LeapYearDays + 2 * YearDays);
        end
    end

    // Stage 6 logic: month and day of month.
    always_comb
    begin
        mon_idx = '0;
        for (int k = 1; k < 12; k++)
        begin
            if (doy_5_reg >= month_start(4'(k), leap_5_reg))
            begin
                mon_idx = mon_idx + 4'd1;
            end
        end
        mday = doy_5_reg - month_start(mon_idx, leap_5_reg);
        if (zero_5_reg)
        begin
            year_6  = '0;
            month_6 = '0;
            day_6   = '0;
        end
        else
        begin
            year_6  = year_5_reg;
            month_6 = mon_idx + 4'd1;
            day_6   = 5'(mday + 9'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode_1_reg <= s_tuser;
            dc_1_reg   <= s_tdata[15:0];
            lo_1_reg   <= s_tdata[16 +: SecShift];
            x_1_reg    <= s_tdata[47:16+SecShift];
            prod_1_reg <= 51'(s_tdata[47:16+SecShift]) * 51'(SecRecip);

            days_2_reg <= mode_1_reg ? q_2 : dc_1_reg;
            rsec_2_reg <= mode_1_reg ? {r_2, lo_1_reg} : 17'd0;

            days_3_reg <= days_2_reg;
            prod_3_reg <= 32'(days_2_reg) * 32'(CycleRecip);
            hour_3_reg <= hour_cnt;

            cyc_4_reg  <= cyc_4;
            rem_4_reg  <= 11'(days_3_reg - 16'(cyc_days_4));
            zero_4_reg <= (days_3_reg == 16'd0);
            hour_4_reg <= hour_3_reg;

            year_5_reg <= 12'(BaseYear) + {4'd0, cyc_4_reg, yoff_5};
            doy_5_reg  <= 9'(rem_4_reg - ysub_5);
            leap_5_reg <= (yoff_5 == 2'd0);
            zero_5_reg <= zero_4_reg;
            hour_5_reg <= hour_4_reg;

            data_6_reg  <= {6'd0, hour_5_reg, day_6, month_6, year_6};
            valid_6_reg <= ~zero_5_reg;
        end
    end

endmodule
